>>> sv/enms_pkg.sv
// Shared types, constants and the sector decode for the edge non-maximum
// suppression block. No dependencies.
package enms_pkg;

  localparam int MAG_W   = 8;
  localparam int ANG_W   = 12;
  localparam int CFG_W   = 12;
  localparam int CFG_IDX_W = 1;
  localparam int MIN_SIZE = 3;

  localparam logic [CFG_W-1:0] RST_FRAME_WIDTH  = 12'd640;
  localparam logic [CFG_W-1:0] RST_FRAME_HEIGHT = 12'd480;

  // Sector limits in eighths of a degree: 22.5, 67.5, 112.5, 157.5
  localparam logic signed [ANG_W-1:0] SECT_A = 12'sd180;
  localparam logic signed [ANG_W-1:0] SECT_B = 12'sd540;
  localparam logic signed [ANG_W-1:0] SECT_C = 12'sd900;
  localparam logic signed [ANG_W-1:0] SECT_D = 12'sd1260;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_WIDTH  = 1'b0,
    CFG_FRAME_HEIGHT = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SECT_HORIZONTAL = 2'd0,
    SECT_VERTICAL   = 2'd1,
    SECT_MINUS_45   = 2'd2,
    SECT_PLUS_45    = 2'd3
  } sector_e;

  typedef logic [8:0][MAG_W-1:0] window_t;

  typedef struct packed {
    logic [ANG_W-1:0] angle;
    logic [MAG_W-1:0] newer;
    logic [MAG_W-1:0] older;
  } line_entry_t;

  function automatic sector_e sector_of(input logic signed [ANG_W-1:0] a);
    sector_e s;
    if ((a > -SECT_C && a <= -SECT_B) || (a > SECT_B && a <= SECT_C)) begin
      s = SECT_VERTICAL;
    end else if ((a > -SECT_B && a <= -SECT_A) || (a > SECT_C && a <= SECT_D)) begin
      s = SECT_MINUS_45;
    end else if ((a > -SECT_D && a <= -SECT_C) || (a > SECT_A && a <= SECT_B)) begin
      s = SECT_PLUS_45;
    end else begin
      s = SECT_HORIZONTAL;
    end
    return s;
  endfunction

endpackage

>>> sv/enms_suppress.sv
// Suppression decision for one 3x3 window: picks the neighbour pair from the
// centre angle and keeps or zeroes the centre. Depends on enms_pkg.
module enms_suppress (
  input  enms_pkg::window_t              win_i,
  input  logic [enms_pkg::ANG_W-1:0]     angle_i,
  output logic [enms_pkg::MAG_W-1:0]     pixel_o
);
  import enms_pkg::*;

  logic [MAG_W-1:0] n1, n2, ctr;

  always_comb begin
    ctr = win_i[4];
    unique case (sector_of(signed'(angle_i)))
      SECT_VERTICAL: begin
        n1 = win_i[1];
        n2 = win_i[7];
      end
      SECT_MINUS_45: begin
        n1 = win_i[2];
        n2 = win_i[6];
      end
      SECT_PLUS_45: begin
        n1 = win_i[0];
        n2 = win_i[8];
      end
      SECT_HORIZONTAL: begin
        n1 = win_i[3];
        n2 = win_i[5];
      end
      default: begin
        n1 = win_i[3];
        n2 = win_i[5];
      end
    endcase
    pixel_o = (ctr < n1 || ctr < n2) ? '0 : ctr;
  end

endmodule

>>> sv/edge_non_maximum_suppression_top.sv
// Top level of the edge non-maximum suppression block: line memory, window,
// counters and output register. Depends on enms_pkg and enms_suppress.
//
// Accepts one pixel (magnitude and angle) per clock while the output is not
// stalled, with no gaps between rows or frames; the single line memory is read
// once and written once per pixel on separate ports, which sets that rate. A
// result enters the output register from the stage 1 register, which holds the
// pixel that completes its window once it is accepted; while a result waits
// there unread, the next result holds off the input. Border pixels
// give no result, so each frame yields (width-2) x (height-2) pixels, with
// tlast on the last pixel of each output row and tuser on the last of the
// frame. Sizes are clamped to 3..MAX_WIDTH and 3..MAX_HEIGHT; a register
// write restarts the frame. The line memory needs no clearing after reset.
module edge_non_maximum_suppression_top #(
  parameter int MAX_WIDTH  = 2048,
  parameter int MAX_HEIGHT = 2048
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [enms_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [enms_pkg::CFG_W-1:0]         cfg_data_i,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  input  logic [23:0]                        s_axis_tdata,  // magnitude[7:0], angle[19:8]
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  output logic [7:0]                         m_axis_tdata,  // pixel_out[7:0]
  output logic                               m_axis_tlast,  // end_of_line
  output logic                               m_axis_tuser   // end_of_frame
);
  import enms_pkg::*;

  localparam int CW  = $clog2(MAX_WIDTH);
  localparam int RW  = $clog2(MAX_HEIGHT);
  localparam int SWW = (CW + 1 > CFG_W) ? CW + 1 : CFG_W;
  localparam int SWH = (RW + 1 > CFG_W) ? RW + 1 : CFG_W;

  logic [CFG_W-1:0] fw_q, fh_q;
  logic [CW:0]      w_eff;
  logic [RW:0]      h_eff;
  logic [SWW-1:0]   fw_ext;
  logic [SWH-1:0]   fh_ext;

  logic [CW-1:0] col_q, col_d;
  logic [RW-1:0] row_q, row_d;

  logic s_accept, s1_adv;
  logic is_eol, is_eof, has_out;

  logic              s1_valid_q;
  logic [CW-1:0]     s1_col_q;
  logic [MAG_W-1:0]  s1_mag_q;
  logic [ANG_W-1:0]  s1_ang_q;
  logic              s1_has_out_q, s1_eol_q, s1_eof_q;

  line_entry_t line_mem [MAX_WIDTH];
  line_entry_t rd_q, wr_entry;

  window_t          win_q, win_d;
  logic [ANG_W-1:0] ctr_ang_q;
  logic [MAG_W-1:0] pix;

  logic             out_valid_q;
  logic [MAG_W-1:0] out_pix_q;
  logic             out_eol_q, out_eof_q;

  // size clamp
  always_comb begin
    fw_ext = SWW'(fw_q);
    fh_ext = SWH'(fh_q);
    if (fw_ext < SWW'(MIN_SIZE)) begin
      w_eff = (CW + 1)'(MIN_SIZE);
    end else if (fw_ext > SWW'(MAX_WIDTH)) begin
      w_eff = (CW + 1)'(MAX_WIDTH);
    end else begin
      w_eff = fw_ext[CW:0];
    end
    if (fh_ext < SWH'(MIN_SIZE)) begin
      h_eff = (RW + 1)'(MIN_SIZE);
    end else if (fh_ext > SWH'(MAX_HEIGHT)) begin
      h_eff = (RW + 1)'(MAX_HEIGHT);
    end else begin
      h_eff = fh_ext[RW:0];
    end
  end

  assign s1_adv        = s1_valid_q && (!s1_has_out_q || !out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  always_comb begin
    is_eol  = ({1'b0, col_q} == w_eff - 1'b1);
    is_eof  = is_eol && ({1'b0, row_q} == h_eff - 1'b1);
    has_out = (row_q >= RW'(2)) && (col_q >= CW'(2));
    col_d   = col_q;
    row_d   = row_q;
    if (is_eol) begin
      col_d = '0;
      row_d = ({1'b0, row_q} == h_eff - 1'b1) ? '0 : row_q + 1'b1;
    end else begin
      col_d = col_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q  <= RST_FRAME_WIDTH;
      fh_q  <= RST_FRAME_HEIGHT;
      col_q <= '0;
      row_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i;
        default: ;
      endcase
      col_q <= '0;
      row_q <= '0;
    end else if (s_accept) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // stage 1 control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s_accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      s1_col_q     <= col_q;
      s1_mag_q     <= s_axis_tdata[7:0];
      s1_ang_q     <= s_axis_tdata[19:8];
      s1_has_out_q <= has_out;
      s1_eol_q     <= is_eol;
      s1_eof_q     <= is_eof;
    end
  end

  // line memory: read at accept, write back when stage 1 retires
  assign wr_entry = '{angle: s1_ang_q, newer: s1_mag_q, older: rd_q.newer};

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      rd_q <= line_mem[col_q];
    end
    if (s1_adv) begin
      line_mem[s1_col_q] <= wr_entry;
    end
  end

  always_comb begin
    win_d    = win_q;
    win_d[0] = win_q[1];
    win_d[1] = win_q[2];
    win_d[2] = rd_q.older;
    win_d[3] = win_q[4];
    win_d[4] = win_q[5];
    win_d[5] = rd_q.newer;
    win_d[6] = win_q[7];
    win_d[7] = win_q[8];
    win_d[8] = s1_mag_q;
  end

  enms_suppress u_suppress (
    .win_i   (win_d),
    .angle_i (ctr_ang_q),
    .pixel_o (pix)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q     <= '0;
      ctr_ang_q <= '0;
    end else if (s1_adv) begin
      win_q     <= win_d;
      ctr_ang_q <= rd_q.angle;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv && s1_has_out_q) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_has_out_q) begin
      out_pix_q <= pix;
      out_eol_q <= s1_eol_q;
      out_eof_q <= s1_eof_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_pix_q;
  assign m_axis_tlast  = out_eol_q;
  assign m_axis_tuser  = out_eof_q;

  // read and write-back never hit the same entry in one cycle
  a_no_rw_clash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_accept && s1_adv |-> s1_col_q != col_q)
    else $error("line memory read and write on the same entry");

  // stalled stage 1 keeps its read data
  a_rd_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_adv |=> $stable(rd_q))
    else $error("read data lost while stage 1 stalled");

  // end of frame only on an end of line
  a_eof_eol: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
    else $error("end of frame without end of line");

endmodule

>>> bench/tb.sv
`timescale 1ns / 1ps
// Testbench for edge_non_maximum_suppression_top: streams gradient pixels through
// the block and checks every output pixel against an in-bench suppression predictor.
// Depends on enms_pkg and the block's RTL.
module tb;
  import enms_pkg::*;

  localparam int MAX_W = 2048;
  localparam int MAX_H = 2048;
  localparam int QUIET_LIMIT = 4000;
  localparam int TOTAL_ITEMS = 1150;
  localparam int SA = SECT_A;
  localparam int SB = SECT_B;
  localparam int SC = SECT_C;
  localparam int SD = SECT_D;

  typedef struct {
    logic [MAG_W-1:0] magnitude;
    logic [ANG_W-1:0] angle;
  } px_item_t;

  typedef struct {
    logic [7:0] pixel;
    logic       eol;
    logic       eof;
  } nms_out_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [23:0]      s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic             m_axis_tlast;
  logic             m_axis_tuser;

  edge_non_maximum_suppression_top #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  px_item_t pixel_q[$];
  nms_out_t kept_q[$];

  // predictor state
  logic [CFG_W-1:0] width_reg = RST_FRAME_WIDTH;
  logic [CFG_W-1:0] height_reg = RST_FRAME_HEIGHT;
  bit [7:0]         older_row [MAX_W];
  bit [7:0]         newer_row [MAX_W];
  bit [11:0]        ang_row [MAX_W];
  bit [7:0]         win [9];
  bit [11:0]        centre_ang;
  int unsigned      col_cnt;
  int unsigned      row_cnt;

  int               mismatches;
  int               quiet_cycles;
  logic             in_taken = 1'b0;
  logic             steady = 1'b0;
  int               send_gap;
  int               ready_hold;
  int               roll;
  px_item_t         next_px;

  function automatic int unsigned clamp_dim(input logic [CFG_W-1:0] v, input int unsigned hi);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic sector_e grad_sector(input logic signed [ANG_W-1:0] a);
    int v;
    v = a;
    if (v > SD || v <= -SD || (v > -SA && v <= SA)) return SECT_HORIZONTAL;
    if ((v > SB && v <= SC) || (v > -SC && v <= -SB)) return SECT_VERTICAL;
    if ((v > SA && v <= SB) || (v > -SD && v <= -SC)) return SECT_PLUS_45;
    return SECT_MINUS_45;
  endfunction

  task automatic suppress_step(input logic [7:0] mag, input logic [11:0] ang);
    int unsigned w, h, c, r;
    logic [7:0]  ctr, n1, n2;
    logic [11:0] prev_ang;
    nms_out_t    res;
    w = clamp_dim(width_reg, MAX_W);
    h = clamp_dim(height_reg, MAX_H);
    c = col_cnt;
    r = row_cnt;
    prev_ang = centre_ang;
    for (int i = 0; i < 3; i++) begin
      win[i*3]   = win[i*3+1];
      win[i*3+1] = win[i*3+2];
    end
    win[2] = older_row[c];
    win[5] = newer_row[c];
    win[8] = mag;
    centre_ang = ang_row[c];
    ang_row[c] = ang;
    older_row[c] = newer_row[c];
    newer_row[c] = mag;
    if (r >= 2 && c >= 2) begin
      ctr = win[4];
      case (grad_sector(prev_ang))
        SECT_VERTICAL: begin
          n1 = win[1];
          n2 = win[7];
        end
        SECT_MINUS_45: begin
          n1 = win[2];
          n2 = win[6];
        end
        SECT_PLUS_45: begin
          n1 = win[0];
          n2 = win[8];
        end
        default: begin
          n1 = win[3];
          n2 = win[5];
        end
      endcase
      res.pixel = (ctr < n1 || ctr < n2) ? 8'd0 : ctr;
      res.eol = (c == w - 1);
      res.eof = res.eol && (r == h - 1);
      kept_q.push_back(res);
    end
    if (c + 1 >= w) begin
      col_cnt = 0;
      row_cnt = (r + 1 >= h) ? 0 : r + 1;
    end else begin
      col_cnt = c + 1;
    end
  endtask

  task automatic note_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  task automatic check_pixel(input logic [7:0] pix, input logic eol, input logic eof);
    nms_out_t want;
    if (kept_q.size() == 0) begin
      note_mismatch($sformatf("unexpected pixel %0d last %0b user %0b", pix, eol, eof));
    end else begin
      want = kept_q.pop_front();
      if (pix !== want.pixel || eol !== want.eol || eof !== want.eof)
        note_mismatch($sformatf("exp pixel %0d last %0b user %0b, got %0d %0b %0b",
                                want.pixel, want.eol, want.eof, pix, eol, eof));
    end
  endtask

  // sampling, prediction, checking, watchdog
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_FRAME_WIDTH) width_reg = cfg_data_i;
        else height_reg = cfg_data_i;
        col_cnt = 0;
        row_cnt = 0;
      end
      if (s_axis_tvalid && s_axis_tready) suppress_step(s_axis_tdata[7:0], s_axis_tdata[19:8]);
      if (m_axis_tvalid && m_axis_tready) check_pixel(m_axis_tdata, m_axis_tlast, m_axis_tuser);
      in_taken <= s_axis_tvalid && s_axis_tready;
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int pick_gap(input logic calm);
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // pixel request driver
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || in_taken) begin
      if (send_gap != 0) begin
        send_gap <= send_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        next_px = pixel_q.pop_front();
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {4'b0000, next_px.angle, next_px.magnitude};
        send_gap <= pick_gap(steady);
        if ($urandom_range(0, 299) == 0) steady <= !steady;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result backpressure
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (steady) begin
      m_axis_tready <= 1'b1;
    end else begin
      roll = $urandom_range(0, 99);
      if (roll < 70) begin
        m_axis_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 6);
      end else if (roll < 95) begin
        m_axis_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else begin
        m_axis_tready <= 1'b0;
        ready_hold <= $urandom_range(10, 40);
      end
    end
  end

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_and_settle();
    while (pixel_q.size() != 0 || s_axis_tvalid) @(posedge clk_i);
    while (kept_q.size() != 0) @(posedge clk_i);
    // border pixels give no result; let the pipeline empty
    repeat (8) @(posedge clk_i);
  endtask

  task automatic push_one(input int mag, input int ang);
    px_item_t it;
    it.magnitude = 8'(mag);
    it.angle = 12'(ang);
    pixel_q.push_back(it);
  endtask

  task automatic push_random(input int n);
    int base, r, ang;
    int marks[10];
    marks = '{180, 540, 900, 1260, 1440, -180, -540, -900, -1260, -1440};
    base = $urandom_range(0, 255);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 63) == 0) base = $urandom_range(0, 255);
      r = $urandom_range(0, 9);
      if (r == 0) push_one(0, 0);
      else if (r == 1) push_one(255, 0);
      else if (r < 5) push_one(base + $urandom_range(0, 2) - 1, 0);
      else push_one($urandom_range(0, 255), 0);
      r = $urandom_range(0, 19);
      if (r < 2) ang = $urandom_range(0, 4095);
      else if (r < 6) ang = marks[$urandom_range(0, 9)] + $urandom_range(0, 2) - 1;
      else ang = $urandom_range(0, 2880) - 1440;
      pixel_q[$].angle = 12'(ang);
    end
  endtask

  initial begin
    int dir_mag[18];
    int dir_ang[18];
    logic [CFG_W-1:0] cur_w, cur_h, wv, hv;
    int fw, fh, n, pick, rand_items;
    dir_mag = '{0, 255, 17, 90, 90, 200,
                128, 100, 100, 100, 255, 60,
                255, 0, 101, 99, 40, 255};
    dir_ang = '{1440, -2048, 2047, 180, 181, -180,
                540, 720, -360, 360, -1440, -1260,
                -1259, 900, 901, 1260, -540, -900};
    cur_w = RST_FRAME_WIDTH;
    cur_h = RST_FRAME_HEIGHT;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // one centre per sector, extreme angles around them
    write_reg(CFG_FRAME_WIDTH, 12'd6);
    write_reg(CFG_FRAME_HEIGHT, 12'd3);
    for (int i = 0; i < 18; i++) push_one(dir_mag[i], dir_ang[i]);
    drain_and_settle();

    // sizes below minimum clamp to 3x3; equal neighbours keep the centre
    write_reg(CFG_FRAME_WIDTH, 12'd0);
    write_reg(CFG_FRAME_HEIGHT, 12'd2);
    for (int i = 0; i < 9; i++) push_one(77, (i == 4) ? 1441 : 0);
    drain_and_settle();
    cur_w = 12'd0;
    cur_h = 12'd2;

    rand_items = 18 + 9;
    while (rand_items < TOTAL_ITEMS) begin
      pick = $urandom_range(0, 2);
      if (pick != 1) begin
        n = $urandom_range(0, 99);
        if (n < 5) wv = $urandom_range(0, 2);
        else if (n < 75) wv = $urandom_range(3, 12);
        else wv = $urandom_range(13, 40);
        write_reg(CFG_FRAME_WIDTH, wv);
        cur_w = wv;
      end
      if (pick != 0) begin
        n = $urandom_range(0, 99);
        if (n < 5) hv = $urandom_range(0, 2);
        else if (n < 85) hv = $urandom_range(3, 6);
        else hv = $urandom_range(7, 16);
        write_reg(CFG_FRAME_HEIGHT, hv);
        cur_h = hv;
      end
      fw = clamp_dim(cur_w, MAX_W);
      fh = clamp_dim(cur_h, MAX_H);
      // large frames would eat the item budget in one go
      if (fw * fh > 300) begin
        write_reg(CFG_FRAME_WIDTH, 12'd5);
        write_reg(CFG_FRAME_HEIGHT, 12'd4);
        cur_w = 12'd5;
        cur_h = 12'd4;
        fw = 5;
        fh = 4;
      end
      n = $urandom_range(1, 3) * fw * fh;
      // sometimes stop mid-frame so the next write restarts it
      if ($urandom_range(0, 3) == 0) n += $urandom_range(1, fw * fh - 1);
      if (n > TOTAL_ITEMS - rand_items) n = TOTAL_ITEMS - rand_items;
      push_random(n);
      rand_items += n;
      drain_and_settle();
    end

    repeat (20) @(posedge clk_i);
    if (kept_q.size() != 0)
      note_mismatch($sformatf("%0d expected pixels never came", kept_q.size()));
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> filelist.f
sv/enms_pkg.sv
sv/enms_suppress.sv
sv/edge_non_maximum_suppression_top.sv
bench/tb.sv
